@@ rtl/core/gb3_pkg.sv @@
// Shared types and constants of the 3x3 Gaussian blur.
// Used by every module of the block; no dependencies of its own.
package gb3_pkg;

    localparam int PIX_W    = 8;
    localparam int ROW_W    = 12;
    localparam int COL_W    = 10;
    localparam int NCOLS_W  = 11;
    localparam int COEF_W   = 16;
    localparam int MAX_COLS = 1024;
    localparam int ADDR_W   = $clog2(MAX_COLS);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 16;
    localparam int TDATA_W  = 32;

    // Smallest frame dimension that the window supports.
    localparam int MIN_DIM  = 3;

    localparam logic [ROW_W-1:0]   ROWS_RESET   = ROW_W'(480);
    localparam logic [NCOLS_W-1:0] COLS_RESET   = NCOLS_W'(640);
    localparam logic [COEF_W-1:0]  CENTER_RESET = COEF_W'(21752);
    localparam logic [COEF_W-1:0]  EDGE_RESET   = COEF_W'(8002);
    localparam logic [COEF_W-1:0]  CORNER_RESET = COEF_W'(2944);

    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [COEF_W-1:0] coef_t;

    // Nine taps, index 3*row + column, top-left first.
    typedef logic [8:0][PIX_W-1:0] win_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last_col;
        logic             last_row;
        logic             emit;
        logic             interior;
    } pos_t;

    // Everything needed to issue the results caused by one input pixel.
    typedef struct packed {
        pos_t pos;
        pix_t value;
        pix_t right;
        pix_t below;
        pix_t corner;
    } job_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_ROWS    = 3'd0,
        CFG_NUM_COLS    = 3'd1,
        CFG_COEF_CENTER = 3'd2,
        CFG_COEF_EDGE   = 3'd3,
        CFG_COEF_CORNER = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        STEP_MAIN,
        STEP_RIGHT,
        STEP_BELOW,
        STEP_CORNER
    } step_t;

endpackage

@@ rtl/core/gb3_line_buffer.sv @@
// Line store and 3x3 window of the Gaussian blur: input stage, memory read,
// window shift and write-back of the two stored lines. Depends on gb3_pkg.
module gb3_line_buffer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  gb3_pkg::pix_t in_pix,
    input  gb3_pkg::pos_t in_pos,
    output logic          out_valid,
    input  logic          out_ready,
    output gb3_pkg::pos_t out_pos,
    output gb3_pkg::win_t out_win
);
    import gb3_pkg::*;

    // Each word holds the pixel two rows up (high byte) and one row up (low byte).
    logic [2*PIX_W-1:0] mem [MAX_COLS];

    logic               a_valid_reg;
    pix_t               a_pix_reg;
    pos_t               a_pos_reg;
    logic [2*PIX_W-1:0] rd_reg;

    logic               b_valid_reg;
    pos_t               b_pos_reg;
    win_t               win_reg;
    win_t               win_next;

    logic               accept;
    logic               a_to_b;
    logic               b_free;
    logic               b_leave;
    pix_t               rd_top;
    pix_t               rd_mid;

    assign rd_top = rd_reg[2*PIX_W-1:PIX_W];
    assign rd_mid = rd_reg[PIX_W-1:0];

    // Items that cause no result retire here without waiting downstream.
    assign b_leave  = b_valid_reg && (!b_pos_reg.emit || out_ready);
    assign b_free   = !b_valid_reg || b_leave;
    assign in_ready = !a_valid_reg || b_free;
    assign accept   = in_valid && in_ready;
    assign a_to_b   = a_valid_reg && b_free;

    always_comb
    begin
        win_next    = win_reg;
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = rd_top;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = rd_mid;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = a_pix_reg;
    end

    // Consecutive pixels always sit in different columns, so the read for a
    // new request never meets the write-back of the one before it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg <= mem[in_pos.col[ADDR_W-1:0]];
        end
        if (a_to_b)
        begin
            mem[a_pos_reg.col[ADDR_W-1:0]] <= {rd_mid, a_pix_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_pix_reg <= in_pix;
            a_pos_reg <= in_pos;
        end
        if (a_to_b)
        begin
            b_pos_reg <= a_pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            win_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_to_b)
            begin
                a_valid_reg <= 1'b0;
            end

            if (a_to_b)
            begin
                b_valid_reg <= 1'b1;
                win_reg     <= win_next;
            end
            else if (b_leave)
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = b_valid_reg && b_pos_reg.emit;
    assign out_pos   = b_pos_reg;
    assign out_win   = win_reg;

`ifndef SYNTHESIS
    a_col_differs: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && b_valid_reg |-> a_pos_reg.col != b_pos_reg.col)
        else $error("line store read and write-back address collide");

    win_shift_once: assert property (@(posedge clk) disable iff (!rst_n)
        a_to_b |=> win_reg[7] == $past(win_reg[8]) && b_valid_reg)
        else $error("window did not shift by one column");
`endif

endmodule

@@ rtl/core/gb3_mac.sv @@
// Weighted sum of the 3x3 window: one stage of products, one stage of
// rounding, saturation and border selection. Depends on gb3_pkg.
module gb3_mac (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  gb3_pkg::pos_t  in_pos,
    input  gb3_pkg::win_t  in_win,
    input  gb3_pkg::coef_t coef_center,
    input  gb3_pkg::coef_t coef_edge,
    input  gb3_pkg::coef_t coef_corner,
    output logic           out_valid,
    input  logic           out_ready,
    output gb3_pkg::job_t  out_job
);
    import gb3_pkg::*;

    localparam int CPROD_W = COEF_W + PIX_W;
    localparam int SUM4_W  = PIX_W + 2;
    localparam int NPROD_W = COEF_W + SUM4_W;
    localparam int ACC_W   = COEF_W + PIX_W + 4;
    localparam int HI_W    = ACC_W - COEF_W;
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_W - 1);

    logic               c_valid_reg;
    pos_t               c_pos_reg;
    logic [CPROD_W-1:0] c_prod_c_reg;
    logic [NPROD_W-1:0] c_prod_e_reg;
    logic [NPROD_W-1:0] c_prod_k_reg;
    pix_t               c_w4_reg;
    pix_t               c_w5_reg;
    pix_t               c_w7_reg;
    pix_t               c_w8_reg;

    logic               d_valid_reg;
    job_t               d_job_reg;

    logic [SUM4_W-1:0]  orth;
    logic [SUM4_W-1:0]  diag;
    logic [ACC_W-1:0]   acc;
    logic [HI_W-1:0]    scaled;
    pix_t               blurred;
    job_t               job_next;
    logic               c_to_d;
    logic               d_free;

    assign orth = SUM4_W'(in_win[1]) + SUM4_W'(in_win[3])
                + SUM4_W'(in_win[5]) + SUM4_W'(in_win[7]);
    assign diag = SUM4_W'(in_win[0]) + SUM4_W'(in_win[2])
                + SUM4_W'(in_win[6]) + SUM4_W'(in_win[8]);

    assign acc = ACC_W'(c_prod_c_reg) + ACC_W'(c_prod_e_reg)
               + ACC_W'(c_prod_k_reg) + ROUND_HALF;
    assign scaled  = acc[ACC_W-1:COEF_W];
    assign blurred = (|scaled[HI_W-1:PIX_W]) ? {PIX_W{1'b1}} : scaled[PIX_W-1:0];

    // Pixels next to the frame border keep their original value.
    always_comb
    begin
        job_next.pos    = c_pos_reg;
        job_next.value  = c_pos_reg.interior ? blurred : c_w4_reg;
        job_next.right  = c_w5_reg;
        job_next.below  = c_w7_reg;
        job_next.corner = c_w8_reg;
    end

    assign d_free   = !d_valid_reg || out_ready;
    assign in_ready = !c_valid_reg || d_free;
    assign c_to_d   = c_valid_reg && d_free;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            c_pos_reg    <= in_pos;
            c_prod_c_reg <= CPROD_W'(coef_center) * CPROD_W'(in_win[4]);
            c_prod_e_reg <= NPROD_W'(coef_edge) * NPROD_W'(orth);
            c_prod_k_reg <= NPROD_W'(coef_corner) * NPROD_W'(diag);
            c_w4_reg     <= in_win[4];
            c_w5_reg     <= in_win[5];
            c_w7_reg     <= in_win[7];
            c_w8_reg     <= in_win[8];
        end
        if (c_to_d)
        begin
            d_job_reg <= job_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                c_valid_reg <= 1'b1;
            end
            else if (c_to_d)
            begin
                c_valid_reg <= 1'b0;
            end

            if (c_to_d)
            begin
                d_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                d_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = d_valid_reg;
    assign out_job   = d_job_reg;

endmodule

@@ rtl/core/gb3_emit.sv @@
// Result sequencer of the Gaussian blur: turns one job into up to four
// results in raster order and holds the output register. Depends on gb3_pkg.
module gb3_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  gb3_pkg::job_t                 in_job,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gb3_pkg::ROW_W-1:0]     out_row,
    output logic [gb3_pkg::COL_W-1:0]     out_col,
    output gb3_pkg::pix_t                 out_value,
    output logic                          out_last,
    output logic                          out_done
);
    import gb3_pkg::*;

    job_t             job_reg;
    logic             job_valid_reg;
    step_t            step_reg;
    step_t            step_next;
    step_t            step_after;

    logic             out_valid_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic [COL_W-1:0] out_col_reg;
    pix_t             out_value_reg;
    logic             out_last_reg;
    logic             out_done_reg;

    logic [ROW_W-1:0] cur_row;
    logic [COL_W-1:0] cur_col;
    pix_t             cur_value;
    logic             cur_last;
    logic             out_free;
    logic             fire;
    logic             load;

    assign out_free = !out_valid_reg || out_ready;
    assign fire     = job_valid_reg && out_free;
    assign in_ready = !job_valid_reg || (out_free && cur_last);
    assign load     = in_valid && in_ready;

    // Order: the pixel up-left of the input, then at the row end the one
    // straight up, on the last row the left one, at the frame end the input.
    always_comb
    begin
        cur_row    = job_reg.pos.row - ROW_W'(1);
        cur_col    = job_reg.pos.col - COL_W'(1);
        cur_value  = job_reg.value;
        cur_last   = 1'b1;
        step_after = STEP_MAIN;
        case (step_reg)
            STEP_MAIN:
            begin
                if (job_reg.pos.last_col)
                begin
                    cur_last   = 1'b0;
                    step_after = STEP_RIGHT;
                end
                else if (job_reg.pos.last_row)
                begin
                    cur_last   = 1'b0;
                    step_after = STEP_BELOW;
                end
            end
            STEP_RIGHT:
            begin
                cur_col   = job_reg.pos.col;
                cur_value = job_reg.right;
                if (job_reg.pos.last_row)
                begin
                    cur_last   = 1'b0;
                    step_after = STEP_BELOW;
                end
            end
            STEP_BELOW:
            begin
                cur_row   = job_reg.pos.row;
                cur_value = job_reg.below;
                if (job_reg.pos.last_col)
                begin
                    cur_last   = 1'b0;
                    step_after = STEP_CORNER;
                end
            end
            STEP_CORNER:
            begin
                cur_row   = job_reg.pos.row;
                cur_col   = job_reg.pos.col;
                cur_value = job_reg.corner;
            end
            default:
            begin
                cur_last = 1'b1;
            end
        endcase

        if (load)
        begin
            step_next = STEP_MAIN;
        end
        else if (fire && !cur_last)
        begin
            step_next = step_after;
        end
        else
        begin
            step_next = step_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_MAIN;
            job_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (load)
            begin
                job_valid_reg <= 1'b1;
            end
            else if (fire && cur_last)
            begin
                job_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= in_job;
        end
        if (fire)
        begin
            out_row_reg   <= cur_row;
            out_col_reg   <= cur_col;
            out_value_reg <= cur_value;
            out_last_reg  <= cur_last;
            out_done_reg  <= cur_last && job_reg.pos.last_row && job_reg.pos.last_col;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;
    assign out_done  = out_done_reg;

`ifndef SYNTHESIS
    done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_done_reg |-> out_last_reg)
        else $error("frame end flagged on a result that is not the last of its run");

    job_held: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !cur_last |=> job_valid_reg && step_reg != STEP_MAIN)
        else $error("job dropped before all its results were issued");

    corner_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg && step_reg == STEP_CORNER
            |-> job_reg.pos.last_col && job_reg.pos.last_row)
        else $error("corner result issued away from the frame end");
`endif

endmodule

@@ rtl/core/gaussian_blur_3x3.sv @@
// 3x3 Gaussian blur on a raster-order stream of 8-bit grey pixels. While m_tready
// is high, one pixel request is taken per clock and results leave one per clock,
// so the input keeps full rate except where a pixel causes more than one result
// (two at the end of each row but the first and on the last row, four for the
// last pixel of a frame), when the output port's one result per cycle sets the
// pace. A result's path runs through the input register with the line store read,
// then the window, product and job registers, the job register of the sequencer
// and the output register. The line store is a single-port-per-side memory of
// 1024 words and needs no clearing after reset. Configuration must be written
// through the cfg port only while no request is in flight; the block does not
// enforce it. Heights below three and widths outside three to 1024 are clamped.
module gaussian_blur_3x3 (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [gb3_pkg::PIX_W-1:0]       s_tdata,   // [7:0] pixel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [gb3_pkg::TDATA_W-1:0]     m_tdata,   // [11:0] out_row, [21:12] out_col,
                                                       // [29:22] out_value, [31:30] zero
    output logic                            m_tlast,   // last_of_run
    output logic                            m_tuser,   // [0] frame_done
    input  logic                            cfg_we,
    input  logic [gb3_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gb3_pkg::CFG_W-1:0]       cfg_data
);
    import gb3_pkg::*;

    logic [ROW_W-1:0]   num_rows_reg;
    logic [NCOLS_W-1:0] num_cols_reg;
    coef_t              coef_center_reg;
    coef_t              coef_edge_reg;
    coef_t              coef_corner_reg;

    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;

    logic [ROW_W-1:0]   rows_used;
    logic [NCOLS_W-1:0] cols_used;
    pos_t               pos;
    logic               accept;

    logic               lb_valid;
    logic               lb_ready;
    pos_t               lb_pos;
    win_t               lb_win;
    logic               mac_valid;
    logic               mac_ready;
    job_t               mac_job;

    logic [ROW_W-1:0]   res_row;
    logic [COL_W-1:0]   res_col;
    pix_t               res_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg    <= ROWS_RESET;
            num_cols_reg    <= COLS_RESET;
            coef_center_reg <= CENTER_RESET;
            coef_edge_reg   <= EDGE_RESET;
            coef_corner_reg <= CORNER_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_NUM_ROWS:    num_rows_reg    <= cfg_data[ROW_W-1:0];
                CFG_NUM_COLS:    num_cols_reg    <= cfg_data[NCOLS_W-1:0];
                CFG_COEF_CENTER: coef_center_reg <= cfg_data[COEF_W-1:0];
                CFG_COEF_EDGE:   coef_edge_reg   <= cfg_data[COEF_W-1:0];
                CFG_COEF_CORNER: coef_corner_reg <= cfg_data[COEF_W-1:0];
                default:         ;
            endcase
        end
    end

    assign rows_used = (num_rows_reg < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : num_rows_reg;
    assign cols_used = (num_cols_reg < NCOLS_W'(MIN_DIM)) ? NCOLS_W'(MIN_DIM) :
                       (num_cols_reg > NCOLS_W'(MAX_COLS)) ? NCOLS_W'(MAX_COLS) :
                       num_cols_reg;

    // A counter at or past the last position counts as being on it.
    always_comb
    begin
        pos.row      = row_reg;
        pos.col      = col_reg;
        pos.last_col = NCOLS_W'(col_reg) >= cols_used - NCOLS_W'(1);
        pos.last_row = row_reg >= rows_used - ROW_W'(1);
        pos.emit     = (row_reg != '0) && (col_reg != '0);
        pos.interior = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));

        if (pos.last_col)
        begin
            col_next = '0;
            row_next = pos.last_row ? '0 : row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    gb3_line_buffer u_line_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pix    (s_tdata),
        .in_pos    (pos),
        .out_valid (lb_valid),
        .out_ready (lb_ready),
        .out_pos   (lb_pos),
        .out_win   (lb_win)
    );

    gb3_mac u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (lb_valid),
        .in_ready    (lb_ready),
        .in_pos      (lb_pos),
        .in_win      (lb_win),
        .coef_center (coef_center_reg),
        .coef_edge   (coef_edge_reg),
        .coef_corner (coef_corner_reg),
        .out_valid   (mac_valid),
        .out_ready   (mac_ready),
        .out_job     (mac_job)
    );

    gb3_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mac_valid),
        .in_ready  (mac_ready),
        .in_job    (mac_job),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_row   (res_row),
        .out_col   (res_col),
        .out_value (res_value),
        .out_last  (m_tlast),
        .out_done  (m_tuser)
    );

    assign m_tdata = {{(TDATA_W - ROW_W - COL_W - PIX_W){1'b0}}, res_value, res_col, res_row};

endmodule
